FILE: rtl/core/dlat_pkg.sv
// Shared widths, codes and types for the device liveness aging table.
`timescale 1ns / 1ps
package dlat_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  localparam int OP_W   = 2;
  localparam int DEV_W  = 48;
  localparam int TIME_W = 32;
  localparam int RES_W  = 3;
  localparam int SLOT_W = 4;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

  localparam logic [OP_W-1:0] OP_ACTIVITY = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP    = 2'd2;

  localparam logic [RES_W-1:0] EV_REFRESHED = 3'd0;
  localparam logic [RES_W-1:0] EV_STORED    = 3'd1;
  localparam logic [RES_W-1:0] EV_FULL      = 3'd2;
  localparam logic [RES_W-1:0] EV_REMOVED   = 3'd3;
  localparam logic [RES_W-1:0] EV_NOT_FOUND = 3'd4;
  localparam logic [RES_W-1:0] EV_EXPIRED   = 3'd5;

  typedef struct packed {
    logic dev_match;
    logic expired;
  } dlat_cmp_t;

endpackage

FILE: rtl/core/dlat_if.sv
// Request and event channel interfaces of the device liveness aging table.
`timescale 1ns / 1ps
interface dlat_req_if import dlat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DEV_W-1:0]  device_id;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, opcode, device_id, now_time, input ready);
  modport sink   (input valid, opcode, device_id, now_time, output ready);
endinterface

interface dlat_evt_if import dlat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RES_W-1:0]  event_res;
  logic [DEV_W-1:0]  event_device;
  logic [SLOT_W-1:0] event_slot;
  logic              last_result;

  modport source (output valid, event_res, event_device, event_slot, last_result,
                  input ready);
  modport sink   (input valid, event_res, event_device, event_slot, last_result,
                  output ready);
endinterface

FILE: rtl/core/dlat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module dlat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/dlat_cmp_unit.sv
// Shared compare unit: address match and wrapping age check for one slot.
`timescale 1ns / 1ps
module dlat_cmp_unit import dlat_pkg::*; (
  input  logic [DEV_W-1:0]  key_dev_i,
  input  logic [TIME_W-1:0] now_time_i,
  input  logic [TIME_W-1:0] timeout_i,
  input  logic [DEV_W-1:0]  ent_dev_i,
  input  logic [TIME_W-1:0] ent_time_i,
  output dlat_cmp_t         cmp_o
);

  logic [TIME_W-1:0] age;

  assign age             = now_time_i - ent_time_i;
  assign cmp_o.dev_match = (key_dev_i == ent_dev_i);
  assign cmp_o.expired   = (age > timeout_i);

endmodule

FILE: rtl/core/device_liveness_aging_table.sv
// Top level of the device liveness aging table: sequencer, valid bits and event register.
`timescale 1ns / 1ps
// Each request walks the slot table once through a single RAM read port and one
// shared compare unit, one slot per cycle unless a sweep holds. A walk goes from
// one accepted request to the next in steps: accept, prime the registered RAM
// read, check each slot in turn and finish. Activity and remove stop at the first
// matching slot. A sweep holds on a slot for as long as the event register is still
// occupied when a further expired slot is found, and the finish cycle of a request
// that reports waits in the same way. Valid bits live in flip-flops and reset clears
// them at once, so there is no clearing pass after reset. The request channel is ready
// only between requests; an unused opcode is taken and ignored.
module device_liveness_aging_table import dlat_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  dlat_req_if.sink          req_i,
  dlat_evt_if.source        evt_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(MAX_RESULTS + 1);
  localparam int RamW = DEV_W + TIME_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [OP_W-1:0]        op_q, op_d;
  logic [DEV_W-1:0]       key_q, key_d;
  logic [TIME_W-1:0]      now_q, now_d;
  logic [TIME_W-1:0]      timeout_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   rd_more_q, rd_more_d;
  logic [IdxW-1:0]        chk_idx_q, chk_idx_d;
  logic                   chk_vld_q, chk_vld_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic                   free_found_q, free_found_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [DEV_W-1:0]       pend_dev_q, pend_dev_d;
  logic [IdxW-1:0]        pend_idx_q, pend_idx_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   evt_vld_q, evt_vld_d;
  logic [RES_W-1:0]       evt_res_q, evt_res_d;
  logic [DEV_W-1:0]       evt_dev_q, evt_dev_d;
  logic [SLOT_W-1:0]      evt_slot_q, evt_slot_d;
  logic                   evt_last_q, evt_last_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  logic [RamW-1:0] ram_rdata;
  dlat_cmp_t       cmp;

  logic out_free;
  logic chk_ent_vld;
  logic sweep_hit;
  logic key_hit;
  logic free_hit;
  logic stall;
  logic need_out;
  logic fin_go;

  dlat_ram #(
    .WIDTH (RamW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({key_q, now_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dlat_cmp_unit u_cmp (
    .key_dev_i  (key_q),
    .now_time_i (now_q),
    .timeout_i  (timeout_q),
    .ent_dev_i  (ram_rdata[TIME_W +: DEV_W]),
    .ent_time_i (ram_rdata[TIME_W-1:0]),
    .cmp_o      (cmp)
  );

  assign out_free    = !evt_vld_q || evt_o.ready;
  assign chk_ent_vld = valid_q[chk_idx_q];
  assign sweep_hit   = chk_vld_q && (op_q == OP_SWEEP) && chk_ent_vld && cmp.expired;
  assign key_hit     = chk_vld_q && ((op_q == OP_ACTIVITY) || (op_q == OP_REMOVE)) &&
                       chk_ent_vld && cmp.dev_match;
  assign free_hit    = chk_vld_q && (op_q == OP_ACTIVITY) && !chk_ent_vld && !free_found_q;
  assign stall       = sweep_hit && pend_vld_q && !out_free;
  assign need_out    = (op_q != OP_SWEEP) || pend_vld_q;
  assign fin_go      = (state_q == ST_FINISH) && (!need_out || out_free);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    now_d        = now_q;
    valid_d      = valid_q;
    rd_idx_d     = rd_idx_q;
    rd_more_d    = rd_more_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = chk_vld_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    pend_vld_d   = pend_vld_q;
    pend_dev_d   = pend_dev_q;
    pend_idx_d   = pend_idx_q;
    cnt_d        = cnt_q;
    evt_vld_d    = evt_vld_q && !evt_o.ready;
    evt_res_d    = evt_res_q;
    evt_dev_d    = evt_dev_q;
    evt_slot_d   = evt_slot_q;
    evt_last_d   = evt_last_q;
    ram_we       = 1'b0;
    ram_waddr    = hit_idx_q;
    ram_raddr    = rd_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid && (req_i.opcode == OP_ACTIVITY || req_i.opcode == OP_REMOVE ||
                            req_i.opcode == OP_SWEEP)) begin
          op_d         = req_i.opcode;
          key_d        = req_i.device_id;
          now_d        = req_i.now_time;
          rd_idx_d     = '0;
          rd_more_d    = 1'b1;
          chk_vld_d    = 1'b0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          pend_vld_d   = 1'b0;
          cnt_d        = '0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (stall) begin
          ram_raddr = chk_idx_q;
        end else begin
          if (rd_more_q) begin
            chk_vld_d = 1'b1;
            chk_idx_d = rd_idx_q;
            if (rd_idx_q == IdxW'(TABLE_DEPTH - 1)) begin
              rd_more_d = 1'b0;
            end else begin
              rd_idx_d = rd_idx_q + IdxW'(1);
            end
          end else begin
            chk_vld_d = 1'b0;
          end
          if (chk_vld_q && !rd_more_q) begin
            state_d = ST_FINISH;
          end
          if (key_hit) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
            state_d   = ST_FINISH;
          end
          if (free_hit) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
          if (sweep_hit) begin
            valid_d[chk_idx_q] = 1'b0;
            if (pend_vld_q) begin
              evt_vld_d  = 1'b1;
              evt_res_d  = EV_EXPIRED;
              evt_dev_d  = pend_dev_q;
              evt_slot_d = SLOT_W'(pend_idx_q);
              evt_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_dev_d = ram_rdata[TIME_W +: DEV_W];
            pend_idx_d = chk_idx_q;
            cnt_d      = cnt_q + CntW'(1);
            if (cnt_q == CntW'(MAX_RESULTS - 1)) begin
              state_d = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        if (fin_go) begin
          state_d = ST_IDLE;
          case (op_q)
            OP_ACTIVITY: begin
              evt_vld_d  = 1'b1;
              evt_dev_d  = key_q;
              evt_last_d = 1'b1;
              if (hit_q) begin
                ram_we     = 1'b1;
                ram_waddr  = hit_idx_q;
                evt_res_d  = EV_REFRESHED;
                evt_slot_d = SLOT_W'(hit_idx_q);
              end else if (free_found_q) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
                evt_res_d           = EV_STORED;
                evt_slot_d          = SLOT_W'(free_idx_q);
              end else begin
                evt_res_d  = EV_FULL;
                evt_slot_d = '0;
              end
            end
            OP_REMOVE: begin
              evt_vld_d  = 1'b1;
              evt_dev_d  = key_q;
              evt_last_d = 1'b1;
              if (hit_q) begin
                valid_d[hit_idx_q] = 1'b0;
                evt_res_d          = EV_REMOVED;
                evt_slot_d         = SLOT_W'(hit_idx_q);
              end else begin
                evt_res_d  = EV_NOT_FOUND;
                evt_slot_d = '0;
              end
            end
            OP_SWEEP: begin
              if (pend_vld_q) begin
                evt_vld_d  = 1'b1;
                evt_res_d  = EV_EXPIRED;
                evt_dev_d  = pend_dev_q;
                evt_slot_d = SLOT_W'(pend_idx_q);
                evt_last_d = 1'b1;
                pend_vld_d = 1'b0;
              end
            end
            default: begin
              evt_vld_d = evt_vld_q && !evt_o.ready;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      timeout_q    <= TIMEOUT_RESET;
      valid_q      <= '0;
      rd_more_q    <= 1'b0;
      chk_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      pend_vld_q   <= 1'b0;
      cnt_q        <= '0;
      evt_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      valid_q      <= valid_d;
      rd_more_q    <= rd_more_d;
      chk_vld_q    <= chk_vld_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      pend_vld_q   <= pend_vld_d;
      cnt_q        <= cnt_d;
      evt_vld_q    <= evt_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    now_q      <= now_d;
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    pend_dev_q <= pend_dev_d;
    pend_idx_q <= pend_idx_d;
    evt_res_q  <= evt_res_d;
    evt_dev_q  <= evt_dev_d;
    evt_slot_q <= evt_slot_d;
    evt_last_q <= evt_last_d;
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign evt_o.valid        = evt_vld_q;
  assign evt_o.event_res    = evt_res_q;
  assign evt_o.event_device = evt_dev_q;
  assign evt_o.event_slot   = evt_slot_q;
  assign evt_o.last_result  = evt_last_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("Sweep result left pending while idle.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_RESULTS))
    else $error("Sweep report count beyond the result limit.");

  a_store_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && (op_q == OP_ACTIVITY) && !hit_q && free_found_q) |=>
    ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("Storing a new device did not claim exactly one free slot.");

  a_sweep_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sweep_hit && pend_vld_q && !stall) |-> out_free)
    else $error("Sweep result pushed over an occupied event register.");

endmodule
